>>> hdl/cbtp_pkg.sv
// Package for the color bar test pattern pixel block.
// Holds field widths, register indexes, payload structs and the bar color table.
// No dependencies; every other file in hdl/ imports it.
package cbtp_pkg;

  // Field and internal widths
  localparam int DIM_W      = 13;             // frame dimension and config data
  localparam int PIX_W      = 12;             // pixel coordinate
  localparam int FRM_W      = 32;             // frame number
  localparam int CH_W       = 8;              // one color byte
  localparam int IDX_W      = 2;              // config register index
  localparam int THR_W      = DIM_W + 3;      // bar thresholds, up to 7 * width
  localparam int NUM_W      = PIX_W + CH_W;   // pixel_x * 255
  localparam int DSH_W      = DIM_W + CH_W;   // divisor shifted by one byte
  localparam int NUM_BARS   = 8;
  localparam int BAR_IDX_W  = 3;

  // Pipeline shape
  localparam int REM_STEPS  = 4;                   // remainder bits per stage
  localparam int REM_STAGES = FRM_W / REM_STEPS;   // sweep remainder stages
  localparam int DIV_STEPS  = 2;                   // quotient bits per stage
  localparam int DIV_STAGES = CH_W / DIV_STEPS;    // ramp divider stages

  // Pattern constants
  localparam int GRID_SH    = 5;                   // grid every 32 pixels
  localparam int SWEEP_SH   = 2;                   // sweep moves 4 pixels a frame
  localparam logic [DIM_W:0]  SWEEP_LEN  = 14'd4;
  localparam logic [DIM_W-1:0] MARKER_MIN = 13'd8;
  localparam logic [CH_W-1:0]  ALPHA      = 8'hFF;
  localparam logic [CH_W-1:0]  LEVEL_MAX  = 8'd255;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIRROR = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  localparam rgb_t GRID_RGB   = '{r: 8'd64,  g: 8'd64,  b: 8'd64};
  localparam rgb_t SWEEP_RGB  = '{r: 8'd255, g: 8'd128, b: 8'd0};
  localparam rgb_t MARK_RED   = '{r: 8'd255, g: 8'd0,   b: 8'd0};
  localparam rgb_t MARK_BLUE  = '{r: 8'd0,   g: 8'd0,   b: 8'd255};

  // Input and result payloads
  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [FRM_W-1:0] frame_number;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
  } out_t;

  // Values derived from the config registers
  typedef struct packed {
    logic [DIM_W-1:0]                 w;
    logic [DIM_W-1:0]                 den;
    logic [DIM_W-1:0]                 ramp_row;
    logic [DIM_W-1:0]                 marker;
    logic                             mirrored;
    logic [NUM_BARS-2:0][THR_W-1:0]   thr;
  } cfg_t;

  // Sweep remainder state: partial remainder and dividend bits still to shift in
  typedef struct packed {
    logic [DIM_W-1:0] rem;
    logic [FRM_W-1:0] bits;
  } rem_t;

  // Ramp divider state
  typedef struct packed {
    logic [DSH_W-1:0] rem;
    logic [CH_W-1:0]  q;
    logic             ovf;
  } div_t;

  // Per-pixel layer flags carried down the pipe
  typedef struct packed {
    logic [PIX_W-1:0]     x;
    logic                 ramp;
    logic                 grid;
    logic                 marker;
    logic [BAR_IDX_W-1:0] bar_idx;
  } pix_t;

  function automatic rgb_t bar_color(input logic [BAR_IDX_W-1:0] idx);
    rgb_t c;
    unique case (idx)
      3'd0: c = '{r: 8'd255, g: 8'd255, b: 8'd255};
      3'd1: c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      3'd2: c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      3'd3: c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      3'd4: c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
      3'd5: c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      3'd6: c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      3'd7: c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
      default: c = '{r: 8'd0, g: 8'd0, b: 8'd0};
    endcase
    return c;
  endfunction

endpackage

>>> hdl/color_bar_test_pattern_pixel.sv
// Color bar test pattern generator, one BGRA pixel per clock. It takes one pixel
// transfer per cycle whenever the output is not stalled. The remainder pipeline
// places the sweep bar, working frame*4 mod width four bits per stage over eight
// stages, with the ramp divider running beside it.
// A stall on the output holds the whole pipe, so nothing is dropped or repeated.
// Config registers (width, height, mirror) are to be written through the cfg port only
// while no pixel is in flight; the block does not enforce it. A write is taken every cycle.
// Depends on cbtp_pkg, cbtp_cfg, cbtp_rem_step and cbtp_div_step.
module color_bar_test_pattern_pixel
  import cbtp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  cfg_t cfg;

  logic                  en;
  logic [REM_STAGES:0]   vld_r;
  in_t                   s0_r;
  pix_t                  pix_r [1:REM_STAGES];
  pix_t                  pix_nxt;
  div_t                  div_r [1:REM_STAGES];
  div_t                  div_nxt;
  rem_t                  rem_r [1:REM_STAGES];
  rem_t                  rem_init;
  logic                  out_valid_r;
  out_t                  out_data_r;
  out_t                  out_nxt;

  logic [DIM_W-1:0]      xw;
  logic [DIM_W-1:0]      yw;
  logic [DIM_W-1:0]      bar_x;
  logic [THR_W-1:0]      bar_x8;
  logic [BAR_IDX_W-1:0]  idx;
  logic [NUM_W-1:0]      num;

  pix_t                  pf;
  logic [DIM_W-1:0]      sweep_x;
  logic                  sweep_hit;
  logic [CH_W-1:0]       level;
  rgb_t                  c;

  cbtp_cfg #(
    .MAX_DIM(MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Advance the whole pipe unless a finished pixel is held at the output
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[REM_STAGES-1:0], in_valid};
      out_valid_r <= vld_r[REM_STAGES];
    end
  end

  // Stage 0: capture the input transfer
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_data;
    end
  end

  // Stage 1: bar index, layer flags, ramp dividend and overflow
  always_comb begin
    xw    = {1'b0, s0_r.pixel_x};
    yw    = {1'b0, s0_r.pixel_y};
    bar_x = xw;
    if (cfg.mirrored) begin
      bar_x = (xw < cfg.w) ? (cfg.w - xw - DIM_W'(1)) : '0;
    end
    bar_x8 = {bar_x, 3'b000};
    idx    = '0;
    for (int k = 0; k < NUM_BARS - 1; k++) begin
      if (bar_x8 >= cfg.thr[k]) begin
        idx = idx + BAR_IDX_W'(1);
      end
    end

    pix_nxt.x       = s0_r.pixel_x;
    pix_nxt.bar_idx = idx;
    pix_nxt.ramp    = (yw >= cfg.ramp_row);
    pix_nxt.grid    = (s0_r.pixel_x[GRID_SH-1:0] == '0) || (s0_r.pixel_y[GRID_SH-1:0] == '0);
    pix_nxt.marker  = (xw < cfg.marker) && (yw < cfg.marker);

    num         = {s0_r.pixel_x, {CH_W{1'b0}}} - {{CH_W{1'b0}}, s0_r.pixel_x};
    div_nxt.rem = {1'b0, num};
    div_nxt.q   = '0;
    div_nxt.ovf = ({1'b0, num} >= {cfg.den, {CH_W{1'b0}}});

    rem_init.rem  = '0;
    rem_init.bits = s0_r.frame_number << SWEEP_SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r[1] <= pix_nxt;
      div_r[1] <= div_nxt;
      for (int k = 2; k <= REM_STAGES; k++) begin
        pix_r[k] <= pix_r[k-1];
      end
    end
  end

  // Stages 1 to 8: sweep remainder, four bits per stage
  for (genvar k = 1; k <= REM_STAGES; k++) begin : g_rem
    rem_t stg_in;
    rem_t stg_nxt;
    if (k == 1) begin : g_first
      assign stg_in = rem_init;
    end else begin : g_next
      assign stg_in = rem_r[k-1];
    end
    cbtp_rem_step u_step (
      .w    (cfg.w),
      .d_in (stg_in),
      .d_out(stg_nxt)
    );
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= stg_nxt;
      end
    end
  end

  // Stages 2 to 5: ramp divider, then hold the level to stage 8
  for (genvar k = 2; k <= REM_STAGES; k++) begin : g_div
    div_t stg_nxt;
    if (k <= DIV_STAGES + 1) begin : g_step
      cbtp_div_step u_step (
        .den  (cfg.den),
        .d_in (div_r[k-1]),
        .d_out(stg_nxt)
      );
    end else begin : g_hold
      assign stg_nxt = div_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k] <= stg_nxt;
      end
    end
  end

  // Output stage: sweep test and layer priority
  always_comb begin
    pf        = pix_r[REM_STAGES];
    sweep_x   = rem_r[REM_STAGES].rem;
    sweep_hit = ({1'b0, pf.x} >= sweep_x) &&
                ({2'b00, pf.x} < ({1'b0, sweep_x} + SWEEP_LEN));
    level     = div_r[REM_STAGES].ovf ? LEVEL_MAX : div_r[REM_STAGES].q;

    priority if (sweep_hit) begin
      c = SWEEP_RGB;
    end else if (pf.marker) begin
      c = cfg.mirrored ? MARK_BLUE : MARK_RED;
    end else if (pf.grid) begin
      c = GRID_RGB;
    end else if (pf.ramp) begin
      c = '{r: level, g: level, b: level};
    end else begin
      c = bar_color(pf.bar_idx);
    end

    out_nxt.blue  = c.b;
    out_nxt.green = c.g;
    out_nxt.red   = c.r;
    out_nxt.alpha = ALPHA;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/cbtp_cfg.sv
// Config registers of the color bar pattern and the values derived from them.
// Depends on cbtp_pkg.
module cbtp_cfg
  import cbtp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  output cfg_t             cfg
);

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             mirror_r;
  cfg_t             cfg_r;
  cfg_t             cfg_nxt;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] min_dim;
  logic [DIM_W-1:0] mk;
  logic [DIM_W-1:0] ht;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = v;
    end
    return d;
  endfunction

  assign cfg_ready = 1'b1;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mirror_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_MIRROR: mirror_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Derive frame geometry
  always_comb begin
    w_eff   = clamp_dim(width_r);
    h_eff   = clamp_dim(height_r);
    min_dim = (w_eff < h_eff) ? w_eff : h_eff;
    mk      = min_dim >> 3;
    ht      = h_eff >> 3;

    cfg_nxt.w        = w_eff;
    cfg_nxt.den      = (w_eff > DIM_W'(1)) ? (w_eff - DIM_W'(1)) : DIM_W'(1);
    cfg_nxt.marker   = (mk > MARKER_MIN) ? mk : MARKER_MIN;
    cfg_nxt.ramp_row = h_eff - ((ht > DIM_W'(1)) ? ht : DIM_W'(1));
    cfg_nxt.mirrored = mirror_r;
    for (int k = 0; k < NUM_BARS - 1; k++) begin
      cfg_nxt.thr[k] = THR_W'(w_eff) * THR_W'(k + 1);
    end
  end

  // Register the derived values
  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/cbtp_rem_step.sv
// One stage of the sweep position remainder: four bits of frame*4 mod width.
// Depends on cbtp_pkg; the caller registers the result.
module cbtp_rem_step
  import cbtp_pkg::*;
(
  input  logic [DIM_W-1:0] w,
  input  rem_t             d_in,
  output rem_t             d_out
);

  logic [DIM_W:0]   t;
  logic [DIM_W-1:0] r;
  logic [FRM_W-1:0] b;

  // Shift in four dividend bits one by one, subtracting the width when it fits
  always_comb begin
    r = d_in.rem;
    b = d_in.bits;
    t = '0;
    for (int i = 0; i < REM_STEPS; i++) begin
      t = {r, b[FRM_W-1]};
      b = {b[FRM_W-2:0], 1'b0};
      if (t >= {1'b0, w}) begin
        t = t - {1'b0, w};
      end
      r = t[DIM_W-1:0];
    end
    d_out.rem  = r;
    d_out.bits = b;
  end

endmodule

>>> hdl/cbtp_div_step.sv
// One stage of the ramp level divider: two quotient bits of x*255 / (width-1).
// Depends on cbtp_pkg; the caller registers the result.
module cbtp_div_step
  import cbtp_pkg::*;
(
  input  logic [DIM_W-1:0] den,
  input  div_t             d_in,
  output div_t             d_out
);

  logic [DSH_W:0]   t;
  logic [DSH_W:0]   dsh;
  logic [DSH_W-1:0] r;
  logic [CH_W-1:0]  q;

  // Restoring division against the divisor shifted up one byte
  always_comb begin
    dsh = {1'b0, den, {CH_W{1'b0}}};
    r   = d_in.rem;
    q   = d_in.q;
    t   = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, 1'b0};
      if (t >= dsh) begin
        t = t - dsh;
        q = {q[CH_W-2:0], 1'b1};
      end else begin
        q = {q[CH_W-2:0], 1'b0};
      end
      r = t[DSH_W-1:0];
    end
    d_out.rem = r;
    d_out.q   = q;
    d_out.ovf = d_in.ovf;
  end

endmodule

>>> hdl/cbtp_chk.sv
// Port checker for the color bar test pattern pixel block, bound to the top level.
// Depends on cbtp_pkg and color_bar_test_pattern_pixel.
module cbtp_chk
  import cbtp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input out_t             out_data,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // Drop any result in flight on reset
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Alpha is always opaque
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.alpha == ALPHA)
    else $error("alpha not opaque");

  // Input back-pressure only while a result waits at the output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // Config writes never wait
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind color_bar_test_pattern_pixel cbtp_chk u_cbtp_chk (.*);
